// ===== hdl/qu8add_pkg.sv =====
// Shared types, codes and constants of the quantized byte element-wise adder.
`default_nettype none

package qu8add_pkg;

	// Default sizes
	localparam int MAX_CHANNELS_DEF   = 256;
	localparam int COEF_FRAC_BITS_DEF = 16;

	// Fixed field widths
	localparam int COEF_W     = 32;
	localparam int TABLES     = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	// Arithmetic widths: s = a*sa + ha + b*sb + hb, product with sc, final sum
	localparam int S_W    = 43;
	localparam int MUL_AW = 33;
	localparam int PROD_W = 65;
	localparam int V_W    = 76;

	// Count caps
	localparam logic [24:0] SPATIAL_CAP = 25'h100_0000;
	localparam logic [16:0] BATCH_CAP   = 17'h1_0000;

	// Item operation codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_COEF = 1'b1;

	// Coefficient table codes
	localparam logic [2:0] TBL_A_SCALE   = 3'd0;
	localparam logic [2:0] TBL_A_SHIFT   = 3'd1;
	localparam logic [2:0] TBL_B_SCALE   = 3'd2;
	localparam logic [2:0] TBL_B_SHIFT   = 3'd3;
	localparam logic [2:0] TBL_OUT_SCALE = 3'd4;
	localparam logic [2:0] TBL_OUT_SHIFT = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd4;

	// Layout codes
	localparam logic LAYOUT_NCHW = 1'b0;
	localparam logic LAYOUT_NHWC = 1'b1;

	// Configuration register set
	typedef struct packed {
		logic        layout;
		logic [8:0]  channel_count;
		logic [24:0] spatial_count;
		logic [16:0] batch_count;
		logic [7:0]  upper_limit;
	} cfg_t;

	// Position of the element being accepted
	typedef struct packed {
		logic [7:0] channel;
		logic       last;
	} pos_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADD,
		ST_ROUND
	} state_t;

	// Multiplier operand selection
	typedef enum logic [1:0] {
		MS_A,
		MS_B,
		MS_SLO,
		MS_SHI
	} mul_sel_t;

	// Commands from controller to datapath, counters and coefficient store
	typedef struct packed {
		logic     coef_wr;
		logic     latch_in;
		logic     rd_en;
		logic     advance;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_ta;
		logic     sum_en;
		logic     acc_hc;
		logic     v_en;
		logic     load_out;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/qu8add_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module qu8add_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/qu8add_pos.sv =====
// Channel, spatial and batch position counters for NCHW and NHWC layouts.
`default_nettype none

module qu8add_pos #(
	parameter int MAX_CHANNELS = qu8add_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qu8add_pkg::cfg_t  cfg,
	input  wire logic              advance,
	output qu8add_pkg::pos_t       pos
);

	localparam int CH_CAP = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

	logic [7:0]  ch_q;
	logic [23:0] sp_q;
	logic [15:0] bt_q;

	logic [8:0]  lim_c;
	logic [24:0] lim_s;
	logic [16:0] lim_b;
	logic        wrap_c, wrap_s, wrap_b;
	logic [7:0]  ch_inc;
	logic [23:0] sp_inc;
	logic [15:0] bt_inc;

	// Effective limits: zero acts as one, large values saturate
	always_comb begin
		if (cfg.channel_count == 9'd0) begin
			lim_c = 9'd1;
		end else if (32'(cfg.channel_count) > CH_CAP) begin
			lim_c = 9'(CH_CAP);
		end else begin
			lim_c = cfg.channel_count;
		end
		if (cfg.spatial_count == 25'd0) begin
			lim_s = 25'd1;
		end else if (cfg.spatial_count > qu8add_pkg::SPATIAL_CAP) begin
			lim_s = qu8add_pkg::SPATIAL_CAP;
		end else begin
			lim_s = cfg.spatial_count;
		end
		if (cfg.batch_count == 17'd0) begin
			lim_b = 17'd1;
		end else if (cfg.batch_count > qu8add_pkg::BATCH_CAP) begin
			lim_b = qu8add_pkg::BATCH_CAP;
		end else begin
			lim_b = cfg.batch_count;
		end
	end

	// Wrap conditions: counter at or past its last value
	assign wrap_c = ({1'b0, ch_q} + 9'd1) >= lim_c;
	assign wrap_s = ({1'b0, sp_q} + 25'd1) >= lim_s;
	assign wrap_b = ({1'b0, bt_q} + 17'd1) >= lim_b;

	assign ch_inc = wrap_c ? 8'd0 : ch_q + 8'd1;
	assign sp_inc = wrap_s ? 24'd0 : sp_q + 24'd1;
	assign bt_inc = wrap_b ? 16'd0 : bt_q + 16'd1;

	assign pos.channel = ch_q;
	assign pos.last    = wrap_c & wrap_s & wrap_b;

	// Counter stepping; batch is always slowest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			sp_q <= '0;
			bt_q <= '0;
		end else if (advance) begin
			if (cfg.layout == qu8add_pkg::LAYOUT_NCHW) begin
				sp_q <= sp_inc;
				if (wrap_s) begin
					ch_q <= ch_inc;
				end
			end else begin
				ch_q <= ch_inc;
				if (wrap_c) begin
					sp_q <= sp_inc;
				end
			end
			if (wrap_s && wrap_c) begin
				bt_q <= bt_inc;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/qu8add_dp.sv =====
// Fixed-point datapath: shared multiplier, accumulators, rounding, clamp, result register.
`default_nettype none

module qu8add_dp #(
	parameter int COEF_FRAC_BITS = qu8add_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire qu8add_pkg::ctrl_cmd_t                   cmd,
	input  wire logic [7:0]                              a_value,
	input  wire logic [7:0]                              b_value,
	input  wire qu8add_pkg::pos_t                        pos,
	input  wire logic [qu8add_pkg::TABLES-1:0][qu8add_pkg::COEF_W-1:0] coef_rd,
	input  wire logic [7:0]                              upper_limit,
	output logic [7:0]                                   c_value,
	output logic [7:0]                                   channel_of_element,
	output logic                                         tensor_last
);

	localparam int F2     = 2 * COEF_FRAC_BITS;
	localparam int HC_W   = qu8add_pkg::COEF_W + COEF_FRAC_BITS;
	localparam int ACC_W  = ((qu8add_pkg::PROD_W > HC_W) ? qu8add_pkg::PROD_W : HC_W) + 1;
	localparam int S_W    = qu8add_pkg::S_W;
	localparam int V_W    = qu8add_pkg::V_W;
	localparam int PROD_W = qu8add_pkg::PROD_W;
	localparam int MUL_AW = qu8add_pkg::MUL_AW;

	// Item and result registers
	logic [7:0] a_q, b_q, ch_q, c_out_q, ch_out_q;
	logic       last_q, last_out_q;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [S_W-1:0]    s_q;
	logic signed [V_W-1:0]    v_q;

	logic signed [31:0]       sa, ha, sb, hb, sc, hc;
	logic signed [MUL_AW-1:0] op_a;
	logic signed [31:0]       op_b;
	logic signed [PROD_W-1:0] mul_p;

	logic       neg, big, round_up;
	logic [7:0] q_floor;
	logic [8:0] q_rnd;
	logic [7:0] c_next;

	assign sa = $signed(coef_rd[qu8add_pkg::TBL_A_SCALE]);
	assign ha = $signed(coef_rd[qu8add_pkg::TBL_A_SHIFT]);
	assign sb = $signed(coef_rd[qu8add_pkg::TBL_B_SCALE]);
	assign hb = $signed(coef_rd[qu8add_pkg::TBL_B_SHIFT]);
	assign sc = $signed(coef_rd[qu8add_pkg::TBL_OUT_SCALE]);
	assign hc = $signed(coef_rd[qu8add_pkg::TBL_OUT_SHIFT]);

	// Operand selection for the shared 33 x 32 multiplier
	always_comb begin
		case (cmd.mul_sel)
			qu8add_pkg::MS_A: begin
				op_a = $signed({25'd0, a_q});
				op_b = sa;
			end
			qu8add_pkg::MS_B: begin
				op_a = $signed({25'd0, b_q});
				op_b = sb;
			end
			qu8add_pkg::MS_SLO: begin
				op_a = $signed({1'b0, s_q[31:0]});
				op_b = sc;
			end
			qu8add_pkg::MS_SHI: begin
				// upper part of s carries the sign
				op_a = MUL_AW'($signed(s_q[S_W-1:32]));
				op_b = sc;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_p = PROD_W'(op_a) * PROD_W'(op_b);

	// Arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			a_q    <= a_value;
			b_q    <= b_value;
			ch_q   <= pos.channel;
			last_q <= pos.last;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.acc_ta) begin
			acc_q <= ACC_W'(prod_q) + ACC_W'(ha);
		end else if (cmd.acc_hc) begin
			acc_q <= ACC_W'(prod_q) + (ACC_W'(hc) <<< COEF_FRAC_BITS);
		end
		if (cmd.sum_en) begin
			s_q <= S_W'(acc_q + ACC_W'(prod_q) + ACC_W'(hb));
		end
		if (cmd.v_en) begin
			v_q <= V_W'(acc_q) + (V_W'(prod_q) <<< 32);
		end
	end

	// Round to nearest, ties to even, then clamp to 0..upper_limit
	assign neg      = v_q[V_W-1];
	assign big      = |v_q[V_W-2:F2+8];
	assign q_floor  = v_q[F2+7:F2];
	assign round_up = v_q[F2-1] & ((|v_q[F2-2:0]) | q_floor[0]);
	assign q_rnd    = {1'b0, q_floor} + {8'd0, round_up};

	always_comb begin
		if (neg) begin
			c_next = 8'd0;
		end else if (big || (q_rnd > {1'b0, upper_limit})) begin
			c_next = upper_limit;
		end else begin
			c_next = q_rnd[7:0];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			c_out_q    <= c_next;
			ch_out_q   <= ch_q;
			last_out_q <= last_q;
		end
	end

	assign c_value            = c_out_q;
	assign channel_of_element = ch_out_q;
	assign tensor_last        = last_out_q;

endmodule

`default_nettype wire

// ===== hdl/qu8add_ctrl.sv =====
// Controller state machine: sequences the multiply steps and owns both handshakes.
`default_nettype none

module qu8add_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           op,
	input  wire logic           out_stall,
	output logic                in_stall,
	output logic                out_valid,
	output qu8add_pkg::ctrl_cmd_t cmd
);

	qu8add_pkg::state_t state_q, state_d;
	logic               out_valid_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qu8add_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			qu8add_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (op == qu8add_pkg::OP_COEF) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.latch_in = 1'b1;
						cmd.rd_en    = 1'b1;
						cmd.advance  = 1'b1;
						state_d      = qu8add_pkg::ST_MUL_A;
					end
				end
			end
			qu8add_pkg::ST_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = qu8add_pkg::MS_A;
				state_d     = qu8add_pkg::ST_MUL_B;
			end
			qu8add_pkg::ST_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = qu8add_pkg::MS_B;
				cmd.acc_ta  = 1'b1;
				state_d     = qu8add_pkg::ST_SUM;
			end
			qu8add_pkg::ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = qu8add_pkg::ST_MUL_LO;
			end
			qu8add_pkg::ST_MUL_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = qu8add_pkg::MS_SLO;
				state_d     = qu8add_pkg::ST_MUL_HI;
			end
			qu8add_pkg::ST_MUL_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = qu8add_pkg::MS_SHI;
				cmd.acc_hc  = 1'b1;
				state_d     = qu8add_pkg::ST_ADD;
			end
			qu8add_pkg::ST_ADD: begin
				cmd.v_en = 1'b1;
				state_d  = qu8add_pkg::ST_ROUND;
			end
			qu8add_pkg::ST_ROUND: begin
				// wait while the previous result is still held
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = qu8add_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qu8add_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != qu8add_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/quantized_u8_elementwise_add.sv =====
// Top level of the quantized byte element-wise adder with per-channel coefficients.
`default_nettype none

// Adds two byte tensors element by element: c = round((a*sa+ha + b*sb+hb)*sc+hc),
// clamped to 0..upper_limit, with signed fixed-point coefficients (COEF_FRAC_BITS
// fraction bits) looked up per channel in six tables. The channel comes from
// position counters that step in NCHW or NHWC order, batch slowest. An item with
// op set writes one coefficient. A data item goes through the coefficient read
// in the cycle it is accepted, four passes through one shared 33 x 32 multiplier,
// the partial-sum add, the wide final add and the rounding step; its result is
// then loaded in the output register, and the next item can be accepted in the
// cycle after that. A finished result waits in the output register while the
// next item is already accepted; if the following result is ready while that
// one is still stalled, the controller and the input stall until it is taken.
// Coefficient entries must be written before use; there is no clearing pass
// after reset. Configuration is written through the cfg port (always ready);
// the user must write it only while the block is idle; the block does not enforce this.
module quantized_u8_elementwise_add #(
	parameter int MAX_CHANNELS   = qu8add_pkg::MAX_CHANNELS_DEF,
	parameter int COEF_FRAC_BITS = qu8add_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input items
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   op,
	input  wire logic [7:0]                             a_value,
	input  wire logic [7:0]                             b_value,
	input  wire logic [2:0]                             coef_table,
	input  wire logic [7:0]                             coef_index,
	input  wire logic signed [qu8add_pkg::COEF_W-1:0]   coef_value,
	// results
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [7:0]                                  c_value,
	output logic [7:0]                                  channel_of_element,
	output logic                                        tensor_last,
	// configuration writes
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [qu8add_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [qu8add_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	qu8add_pkg::cfg_t      cfg_q;
	qu8add_pkg::ctrl_cmd_t cmd;
	qu8add_pkg::pos_t      pos;

	logic [qu8add_pkg::TABLES-1:0][qu8add_pkg::COEF_W-1:0] coef_rd;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          idx_ok;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layout        <= qu8add_pkg::LAYOUT_NCHW;
			cfg_q.channel_count <= 9'd1;
			cfg_q.spatial_count <= 25'd1;
			cfg_q.batch_count   <= 17'd1;
			cfg_q.upper_limit   <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qu8add_pkg::REG_LAYOUT:        cfg_q.layout        <= cfg_data[0];
				qu8add_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[8:0];
				qu8add_pkg::REG_SPATIAL_COUNT: cfg_q.spatial_count <= cfg_data;
				qu8add_pkg::REG_BATCH_COUNT:   cfg_q.batch_count   <= cfg_data[16:0];
				qu8add_pkg::REG_UPPER_LIMIT:   cfg_q.upper_limit   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Controller
	qu8add_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Position counters
	qu8add_pos #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (cmd.advance),
		.pos     (pos)
	);

	// Coefficient store addressing; out-of-range channels are dropped on write
	assign idx_ok  = 32'(coef_index) < MAX_CHANNELS;
	assign wr_addr = AW'(coef_index);
	assign rd_addr = (32'(pos.channel) < MAX_CHANNELS) ? AW'(pos.channel) : '0;

	// One RAM per coefficient table, all read in the same cycle
	for (genvar t = 0; t < qu8add_pkg::TABLES; t++) begin : g_tbl
		qu8add_ram #(
			.WIDTH (qu8add_pkg::COEF_W),
			.DEPTH (MAX_CHANNELS),
			.AW    (AW)
		) u_ram (
			.clk   (clk),
			.we    (cmd.coef_wr && idx_ok && (coef_table == 3'(t))),
			.waddr (wr_addr),
			.wdata (coef_value),
			.re    (cmd.rd_en),
			.raddr (rd_addr),
			.rdata (coef_rd[t])
		);
	end

	// Datapath
	qu8add_dp #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk                (clk),
		.cmd                (cmd),
		.a_value            (a_value),
		.b_value            (b_value),
		.pos                (pos),
		.coef_rd            (coef_rd),
		.upper_limit        (cfg_q.upper_limit),
		.c_value            (c_value),
		.channel_of_element (channel_of_element),
		.tensor_last        (tensor_last)
	);

endmodule

`default_nettype wire
